[hdl/rlyatt_pkg.sv]
// Package for the relay attenuator sequencer: word types, command type and codes.
// Used by every module in hdl; depends on nothing.
package rlyatt_pkg;

   // Request operations.
   localparam logic [1:0] OP_BOTH_LEVEL = 2'd0;
   localparam logic [1:0] OP_ONE_LEVEL  = 2'd1;
   localparam logic [1:0] OP_BOTH_RAW   = 2'd2;
   localparam logic [1:0] OP_ONE_RAW    = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BALANCE = 2'd0;
   localparam logic [1:0] CSR_EXTRA   = 2'd1;
   localparam logic [1:0] CSR_SETTLE  = 2'd2;

   localparam logic [7:0] BALANCE_CENTER = 8'd128;
   localparam logic [7:0] BALANCE_MIN    = 8'd28;
   localparam logic [7:0] BALANCE_MAX    = 8'd228;
   localparam logic [7:0] EXTRA_RESET    = 8'd0;
   localparam logic [6:0] SETTLE_RESET   = 7'd10;
   localparam logic [7:0] CODE_MAX       = 8'd255;
   localparam logic [7:0] LEVEL_MAX      = 8'd100;

   // Expander addresses and registers.
   localparam logic [5:0] ADDR_LEFT  = 6'h20;
   localparam logic [5:0] ADDR_RIGHT = 6'h21;
   localparam logic [2:0] REG_SET    = 3'd2;
   localparam logic [2:0] REG_RESET  = 3'd3;
   localparam logic [2:0] REG_CFG0   = 3'd6;
   localparam logic [2:0] REG_CFG1   = 3'd7;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Step counter of the back end.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] LAST_STEP_BOTH   = 5'd17;
   localparam logic [STEP_W-1:0] LAST_STEP_SINGLE = 5'd9;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_WAIT   = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_REJECT = 2'd0,
      MODE_BOTH   = 2'd1,
      MODE_SINGLE = 2'd2
   } cmd_mode_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] level;
      logic       right_side;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] device_address;
      logic [2:0] register_index;
      logic [7:0] write_value;
      logic [6:0] wait_ms;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] balance;
      logic [7:0] extra_attenuation;
      logic [6:0] settle_ms;
   } config_type;

   // A classified request: for one channel, code_left carries its code.
   typedef struct packed {
      cmd_mode_type mode;
      logic         right_side;
      logic [7:0]   code_left;
      logic [7:0]   code_right;
   } cmd_type;

endpackage

[hdl/relay_attenuator_sequencer.sv]
// Relay attenuator sequencer: configuration registers and the front, queue and back ends.
// Depends on rlyatt_pkg, rlyatt_front, rlyatt_queue and rlyatt_back.
// A request passes through a queue entry and the back end's command register before its
// first result word reaches the result register. Throughput: one result word per cycle
// while rsp_ready allows; two-channel requests give 18 words, one-channel 10, rejected 1.
// Reset: balance 128, extra attenuation 0, settle time 10 ms; queue and result empty.
module relay_attenuator_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rlyatt_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rlyatt_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data
);

   rlyatt_pkg::config_type cfg_ff, cfg_in;
   rlyatt_pkg::cmd_type    front_cmd;
   rlyatt_pkg::cmd_type    q_head;
   logic                   q_full;
   logic                   q_not_empty;
   logic                   q_pop;
   logic                   q_push;

   assign csr_ready = 1'b1;

   // A balance word outside the usable range leaves the register as it was.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rlyatt_pkg::CSR_BALANCE: begin
               if ((csr_data >= rlyatt_pkg::BALANCE_MIN) &&
                   (csr_data <= rlyatt_pkg::BALANCE_MAX)) begin
                  cfg_in.balance = csr_data;
               end
            end
            rlyatt_pkg::CSR_EXTRA:  cfg_in.extra_attenuation = csr_data;
            rlyatt_pkg::CSR_SETTLE: cfg_in.settle_ms = csr_data[6:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.balance           <= rlyatt_pkg::BALANCE_CENTER;
         cfg_ff.extra_attenuation <= rlyatt_pkg::EXTRA_RESET;
         cfg_ff.settle_ms         <= rlyatt_pkg::SETTLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   rlyatt_front u_front (
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cmd      (front_cmd)
   );

   rlyatt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   rlyatt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

[hdl/rlyatt_front.sv]
// Front end: classifies a request and works out the channel codes.
// Depends on rlyatt_pkg; feeds rlyatt_queue.
module rlyatt_front (
   input  rlyatt_pkg::req_type    req_data,
   input  rlyatt_pkg::config_type cfg,
   output rlyatt_pkg::cmd_type    cmd
);

   logic [7:0] lv;
   logic [7:0] level_code;
   logic [7:0] code;
   logic [7:0] off_left;
   logic [7:0] off_right;
   logic [8:0] sum_left;
   logic [8:0] sum_right;
   logic [7:0] bal_left;
   logic [7:0] bal_right;
   logic [8:0] ext_left;
   logic [8:0] ext_right;
   logic       by_level;
   logic       both;

   assign lv = req_data.level;
   assign by_level = (req_data.operation == rlyatt_pkg::OP_BOTH_LEVEL) ||
                     (req_data.operation == rlyatt_pkg::OP_ONE_LEVEL);
   assign both = (req_data.operation == rlyatt_pkg::OP_BOTH_LEVEL) ||
                 (req_data.operation == rlyatt_pkg::OP_BOTH_RAW);

   // Piecewise volume curve: steeper steps toward the quiet end.
   always_comb begin
      if (lv >= 8'd25) begin
         level_code = 8'(8'd100 - lv);
      end else if (lv >= 8'd10) begin
         level_code = 8'(8'd75 + 8'(8'(8'd25 - lv) * 8'd2));
      end else if (lv >= 8'd6) begin
         level_code = 8'(8'd105 + 8'(8'(8'd10 - lv) * 8'd4));
      end else if (lv >= 8'd3) begin
         level_code = 8'(8'd121 + 8'(8'(8'd6 - lv) * 8'd6));
      end else if (lv >= 8'd1) begin
         level_code = 8'(8'd139 + 8'(8'(8'd3 - lv) * 8'd10));
      end else begin
         level_code = rlyatt_pkg::CODE_MAX;
      end
   end

   assign code = by_level ? level_code : lv;

   // Balance attenuates the side it leans away from.
   assign off_left  = (cfg.balance > rlyatt_pkg::BALANCE_CENTER) ?
                      8'(cfg.balance - rlyatt_pkg::BALANCE_CENTER) : 8'd0;
   assign off_right = (cfg.balance < rlyatt_pkg::BALANCE_CENTER) ?
                      8'(rlyatt_pkg::BALANCE_CENTER - cfg.balance) : 8'd0;

   assign sum_left  = {1'b0, code} + {1'b0, (both ? off_left : 8'd0)};
   assign sum_right = {1'b0, code} + {1'b0, off_right};
   assign bal_left  = sum_left[8]  ? rlyatt_pkg::CODE_MAX : sum_left[7:0];
   assign bal_right = sum_right[8] ? rlyatt_pkg::CODE_MAX : sum_right[7:0];
   assign ext_left  = {1'b0, bal_left}  + {1'b0, cfg.extra_attenuation};
   assign ext_right = {1'b0, bal_right} + {1'b0, cfg.extra_attenuation};

   always_comb begin
      cmd.right_side = req_data.right_side;
      cmd.code_left  = ext_left[8]  ? rlyatt_pkg::CODE_MAX : ext_left[7:0];
      cmd.code_right = ext_right[8] ? rlyatt_pkg::CODE_MAX : ext_right[7:0];
      if (by_level && (lv > rlyatt_pkg::LEVEL_MAX)) begin
         cmd.mode = rlyatt_pkg::MODE_REJECT;
      end else if (both) begin
         cmd.mode = rlyatt_pkg::MODE_BOTH;
      end else begin
         cmd.mode = rlyatt_pkg::MODE_SINGLE;
      end
   end

endmodule

[hdl/rlyatt_queue.sv]
// Short command queue between the front and back ends.
// Depends on rlyatt_pkg for the command type and depth.
module rlyatt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rlyatt_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output rlyatt_pkg::cmd_type head_cmd
);

   rlyatt_pkg::cmd_type                  entry_ff [rlyatt_pkg::QUEUE_DEPTH];
   logic [rlyatt_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rlyatt_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rlyatt_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == rlyatt_pkg::QUEUE_CNT_W'(rlyatt_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   function automatic logic [rlyatt_pkg::QUEUE_PTR_W-1:0] next_ptr(
      input logic [rlyatt_pkg::QUEUE_PTR_W-1:0] ptr);
      if (ptr == rlyatt_pkg::QUEUE_PTR_W'(rlyatt_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/rlyatt_back.sv]
// Back end: steps through the write and wait sequence of one command per request, one
// word a cycle into the result register unless rsp_ready stalls. Depends on rlyatt_pkg.
module rlyatt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rlyatt_pkg::config_type cfg,
   input  logic                   q_not_empty,
   input  rlyatt_pkg::cmd_type    q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rlyatt_pkg::rsp_type    rsp_data
);

   rlyatt_pkg::cmd_type           cmd_ff, cmd_in;
   logic                          active_ff, active_in;
   logic [rlyatt_pkg::STEP_W-1:0] step_ff, step_in;
   logic                          out_valid_ff, out_valid_in;
   rlyatt_pkg::rsp_type           out_ff, out_in;
   rlyatt_pkg::rsp_type           word;
   logic [rlyatt_pkg::STEP_W-1:0] last_step;
   logic                          advance;
   logic                          at_last;
   logic [5:0]                    single_addr;

   assign single_addr = cmd_ff.right_side ? rlyatt_pkg::ADDR_RIGHT : rlyatt_pkg::ADDR_LEFT;

   always_comb begin
      case (cmd_ff.mode)
         rlyatt_pkg::MODE_BOTH:   last_step = rlyatt_pkg::LAST_STEP_BOTH;
         rlyatt_pkg::MODE_SINGLE: last_step = rlyatt_pkg::LAST_STEP_SINGLE;
         default:                 last_step = '0;
      endcase
   end

   assign at_last = (step_ff == last_step);
   assign advance = active_ff && (!out_valid_ff || rsp_ready);

   // Word for the current step; fields not used by a word stay zero.
   always_comb begin
      word                = '0;
      word.kind           = rlyatt_pkg::KIND_WRITE;
      word.last           = at_last;
      case (cmd_ff.mode)
         rlyatt_pkg::MODE_BOTH: begin
            case (step_ff)
               5'd0:  begin word.device_address = rlyatt_pkg::ADDR_LEFT;
                            word.register_index = rlyatt_pkg::REG_CFG0; end
               5'd1:  begin word.device_address = rlyatt_pkg::ADDR_LEFT;
                            word.register_index = rlyatt_pkg::REG_CFG1; end
               5'd2:  begin word.device_address = rlyatt_pkg::ADDR_RIGHT;
                            word.register_index = rlyatt_pkg::REG_CFG0; end
               5'd3:  begin word.device_address = rlyatt_pkg::ADDR_RIGHT;
                            word.register_index = rlyatt_pkg::REG_CFG1; end
               5'd4, 5'd9: begin
                  word.device_address = rlyatt_pkg::ADDR_LEFT;
                  word.register_index = rlyatt_pkg::REG_SET;
                  word.write_value    = cmd_ff.code_left;
               end
               5'd5:  begin word.device_address = rlyatt_pkg::ADDR_LEFT;
                            word.register_index = rlyatt_pkg::REG_RESET; end
               5'd6, 5'd11: begin
                  word.device_address = rlyatt_pkg::ADDR_RIGHT;
                  word.register_index = rlyatt_pkg::REG_SET;
                  word.write_value    = cmd_ff.code_right;
               end
               5'd7:  begin word.device_address = rlyatt_pkg::ADDR_RIGHT;
                            word.register_index = rlyatt_pkg::REG_RESET; end
               5'd8, 5'd13: begin
                  word.kind    = rlyatt_pkg::KIND_WAIT;
                  word.wait_ms = cfg.settle_ms;
               end
               5'd10: begin
                  word.device_address = rlyatt_pkg::ADDR_LEFT;
                  word.register_index = rlyatt_pkg::REG_RESET;
                  word.write_value    = ~cmd_ff.code_left;
               end
               5'd12: begin
                  word.device_address = rlyatt_pkg::ADDR_RIGHT;
                  word.register_index = rlyatt_pkg::REG_RESET;
                  word.write_value    = ~cmd_ff.code_right;
               end
               5'd14: begin word.device_address = rlyatt_pkg::ADDR_LEFT;
                            word.register_index = rlyatt_pkg::REG_SET; end
               5'd15: begin word.device_address = rlyatt_pkg::ADDR_LEFT;
                            word.register_index = rlyatt_pkg::REG_RESET; end
               5'd16: begin word.device_address = rlyatt_pkg::ADDR_RIGHT;
                            word.register_index = rlyatt_pkg::REG_SET; end
               5'd17: begin word.device_address = rlyatt_pkg::ADDR_RIGHT;
                            word.register_index = rlyatt_pkg::REG_RESET; end
               default: begin
                  word.device_address = '0;
               end
            endcase
         end
         rlyatt_pkg::MODE_SINGLE: begin
            word.device_address = single_addr;
            case (step_ff)
               5'd0: word.register_index = rlyatt_pkg::REG_CFG0;
               5'd1: word.register_index = rlyatt_pkg::REG_CFG1;
               5'd2, 5'd5: begin
                  word.register_index = rlyatt_pkg::REG_SET;
                  word.write_value    = cmd_ff.code_left;
               end
               5'd3, 5'd9: word.register_index = rlyatt_pkg::REG_RESET;
               5'd4, 5'd7: begin
                  word.kind           = rlyatt_pkg::KIND_WAIT;
                  word.device_address = '0;
                  word.wait_ms        = cfg.settle_ms;
               end
               5'd6: begin
                  word.register_index = rlyatt_pkg::REG_RESET;
                  word.write_value    = ~cmd_ff.code_left;
               end
               5'd8: word.register_index = rlyatt_pkg::REG_SET;
               default: word.register_index = '0;
            endcase
         end
         default: begin
            word.kind = rlyatt_pkg::KIND_REJECT;
         end
      endcase
   end

   // The next command is taken in the same cycle as the last word of the
   // current one, so sequences run without a gap.
   assign q_pop = q_not_empty && (!active_ff || (advance && at_last));

   always_comb begin
      cmd_in       = cmd_ff;
      active_in    = active_ff;
      step_in      = step_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_in       = word;
         out_valid_in = 1'b1;
         step_in      = step_ff + 1'b1;
         if (at_last) begin
            active_in = 1'b0;
         end
      end
      if (q_pop) begin
         cmd_in    = q_head;
         active_in = 1'b1;
         step_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[dv/relay_attenuator_sequencer_tb.sv]
// Testbench for the relay attenuator sequencer: predicts every result word of each request
// and checks the words in order, under several register settings and random idling.
// Depends on rlyatt_pkg and relay_attenuator_sequencer in hdl.
module relay_attenuator_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   localparam int         RANDOM_PHASES = 7;
   localparam int         PHASE_ITEMS   = 14;
   localparam int         IDLE_PERCENT  = 16;
   localparam int         CYCLE_LIMIT   = 200000;

   // Keeps its own copy of the registers and the queue of result words still to come.
   class relay_sequence_scoreboard;
      logic [7:0]          balance;
      logic [7:0]          extra_attenuation;
      logic [6:0]          settle_ms;
      rlyatt_pkg::rsp_type expected_words[$];
      int                  failures;
      int                  requests_noted;
      int                  rejects_noted;
      int                  words_checked;

      function new();
         balance           = rlyatt_pkg::BALANCE_CENTER;
         extra_attenuation = rlyatt_pkg::EXTRA_RESET;
         settle_ms         = rlyatt_pkg::SETTLE_RESET;
         failures          = 0;
         requests_noted    = 0;
         rejects_noted     = 0;
         words_checked     = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void write_register(logic [1:0] index, logic [7:0] value);
         case (index)
            rlyatt_pkg::CSR_BALANCE: begin
               if (value >= rlyatt_pkg::BALANCE_MIN && value <= rlyatt_pkg::BALANCE_MAX)
                  balance = value;
            end
            rlyatt_pkg::CSR_EXTRA: begin
               extra_attenuation = value;
            end
            rlyatt_pkg::CSR_SETTLE: begin
               settle_ms = value[6:0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic [7:0] saturate_add(logic [7:0] a, logic [7:0] b);
         logic [8:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[8] ? rlyatt_pkg::CODE_MAX : sum[7:0];
      endfunction

      // Piecewise volume curve: coarser steps toward the quiet end, level 0 is full mute.
      function logic [7:0] level_code(logic [7:0] level);
         int unsigned lv;
         lv = level;
         if (lv >= 25) return 8'(100 - lv);
         if (lv >= 10) return 8'(75 + (25 - lv) * 2);
         if (lv >= 6) return 8'(105 + (10 - lv) * 4);
         if (lv >= 3) return 8'(121 + (6 - lv) * 6);
         if (lv >= 1) return 8'(139 + (3 - lv) * 10);
         return rlyatt_pkg::CODE_MAX;
      endfunction

      function void push_word(rlyatt_pkg::kind_type kind, logic [5:0] address,
                              logic [2:0] index, logic [7:0] value, logic [6:0] pause_ms,
                              logic last);
         rlyatt_pkg::rsp_type word;
         word.kind           = kind;
         word.device_address = address;
         word.register_index = index;
         word.write_value    = value;
         word.wait_ms        = pause_ms;
         word.last           = last;
         expected_words.push_back(word);
      endfunction

      function void note_request(rlyatt_pkg::req_type item);
         logic [5:0] address[2];
         logic [7:0] code[2];
         logic [7:0] base;
         logic [7:0] left_code;
         logic [7:0] right_code;
         int         channels;
         bit         by_level;
         requests_noted++;
         by_level = (item.operation == rlyatt_pkg::OP_BOTH_LEVEL ||
                     item.operation == rlyatt_pkg::OP_ONE_LEVEL);
         if (by_level && item.level > rlyatt_pkg::LEVEL_MAX) begin
            rejects_noted++;
            push_word(rlyatt_pkg::KIND_REJECT, '0, '0, '0, '0, 1'b1);
            return;
         end
         base = by_level ? level_code(item.level) : item.level;
         if (item.operation == rlyatt_pkg::OP_BOTH_LEVEL ||
             item.operation == rlyatt_pkg::OP_BOTH_RAW) begin
            left_code  = base;
            right_code = base;
            // Balance pushes the far channel down; the centered setting touches neither.
            if (balance > rlyatt_pkg::BALANCE_CENTER)
               left_code = saturate_add(left_code, balance - rlyatt_pkg::BALANCE_CENTER);
            else if (balance < rlyatt_pkg::BALANCE_CENTER)
               right_code = saturate_add(right_code, rlyatt_pkg::BALANCE_CENTER - balance);
            channels   = 2;
            address[0] = rlyatt_pkg::ADDR_LEFT;
            address[1] = rlyatt_pkg::ADDR_RIGHT;
            code[0]    = saturate_add(left_code, extra_attenuation);
            code[1]    = saturate_add(right_code, extra_attenuation);
         end else begin
            channels   = 1;
            address[0] = item.right_side ? rlyatt_pkg::ADDR_RIGHT : rlyatt_pkg::ADDR_LEFT;
            code[0]    = saturate_add(base, extra_attenuation);
         end
         for (int i = 0; i < channels; i++) begin
            push_word(rlyatt_pkg::KIND_WRITE, address[i], rlyatt_pkg::REG_CFG0, '0, '0, 1'b0);
            push_word(rlyatt_pkg::KIND_WRITE, address[i], rlyatt_pkg::REG_CFG1, '0, '0, 1'b0);
         end
         for (int i = 0; i < channels; i++) begin
            push_word(rlyatt_pkg::KIND_WRITE, address[i], rlyatt_pkg::REG_SET, code[i],
                      '0, 1'b0);
            push_word(rlyatt_pkg::KIND_WRITE, address[i], rlyatt_pkg::REG_RESET, '0,
                      '0, 1'b0);
         end
         push_word(rlyatt_pkg::KIND_WAIT, '0, '0, '0, settle_ms, 1'b0);
         for (int i = 0; i < channels; i++) begin
            push_word(rlyatt_pkg::KIND_WRITE, address[i], rlyatt_pkg::REG_SET, code[i],
                      '0, 1'b0);
            push_word(rlyatt_pkg::KIND_WRITE, address[i], rlyatt_pkg::REG_RESET,
                      rlyatt_pkg::CODE_MAX - code[i], '0, 1'b0);
         end
         push_word(rlyatt_pkg::KIND_WAIT, '0, '0, '0, settle_ms, 1'b0);
         for (int i = 0; i < channels; i++) begin
            push_word(rlyatt_pkg::KIND_WRITE, address[i], rlyatt_pkg::REG_SET, '0, '0, 1'b0);
            push_word(rlyatt_pkg::KIND_WRITE, address[i], rlyatt_pkg::REG_RESET, '0, '0,
                      i == channels - 1);
         end
      endfunction

      function void compare_field(string name, logic [7:0] wanted, logic [7:0] actual);
         if (actual !== wanted) begin
            failures++;
            $error("%s: expected %0d, actual %0d", name, wanted, actual);
         end
      endfunction

      function void check_word(rlyatt_pkg::rsp_type actual);
         rlyatt_pkg::rsp_type wanted;
         if (expected_words.size() == 0) begin
            failures++;
            $error("result word %h arrived with nothing expected", actual);
            return;
         end
         wanted = expected_words.pop_front();
         words_checked++;
         compare_field("kind", wanted.kind, actual.kind);
         compare_field("device_address", wanted.device_address, actual.device_address);
         compare_field("register_index", wanted.register_index, actual.register_index);
         compare_field("write_value", wanted.write_value, actual.write_value);
         compare_field("wait_ms", wanted.wait_ms, actual.wait_ms);
         compare_field("last", wanted.last, actual.last);
      endfunction
   endclass

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   rlyatt_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rlyatt_pkg::rsp_type rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = '0;
   logic [7:0]          csr_data  = '0;

   relay_sequence_scoreboard scoreboard;
   bit steady = 1'b0;
   int cycles = 0;
   int settings_used = 1;

   relay_attenuator_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: check every accepted word, then pick the ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) scoreboard.check_word(rsp_data);
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Valid stays high after a word is taken, so back-to-back words never toggle it.
   task automatic send_request(input rlyatt_pkg::req_type item);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scoreboard.note_request(item);
   endtask

   task automatic send_fields(input logic [1:0] operation, input logic [7:0] level,
                              input logic right_side);
      rlyatt_pkg::req_type item;
      item.operation  = operation;
      item.level      = level;
      item.right_side = right_side;
      send_request(item);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scoreboard.write_register(index, value);
   endtask

   // The unused index is written last so a stray decode would show up in the next phase.
   task automatic configure(input logic [7:0] balance, input logic [7:0] extra,
                            input logic [7:0] settle);
      write_register(rlyatt_pkg::CSR_BALANCE, balance);
      write_register(rlyatt_pkg::CSR_EXTRA, extra);
      write_register(rlyatt_pkg::CSR_SETTLE, settle);
      write_register(CSR_UNUSED, 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   function automatic rlyatt_pkg::req_type random_request();
      rlyatt_pkg::req_type item;
      item.operation  = 2'($urandom_range(0, 3));
      item.right_side = 1'($urandom_range(0, 1));
      if (item.operation == rlyatt_pkg::OP_BOTH_RAW || item.operation == rlyatt_pkg::OP_ONE_RAW ||
          $urandom_range(0, 7) == 0)
         item.level = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 2) == 0)
         item.level = 8'($urandom_range(0, 25));
      else
         item.level = 8'($urandom_range(0, 100));
      return item;
   endfunction

   function automatic logic [7:0] random_extra();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 30));
   endfunction

   initial begin
      scoreboard = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every segment of the volume curve, its edges, mute and the rejected levels.
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd0, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd1, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd2, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd3, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd5, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd6, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd9, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd10, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd24, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd25, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd100, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd101, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd255, 1'b1);
      // The side select must make no difference to a two-channel request.
      send_fields(rlyatt_pkg::OP_BOTH_LEVEL, 8'd50, 1'b1);
      send_fields(rlyatt_pkg::OP_ONE_LEVEL, 8'd0, 1'b0);
      send_fields(rlyatt_pkg::OP_ONE_LEVEL, 8'd100, 1'b1);
      send_fields(rlyatt_pkg::OP_ONE_LEVEL, 8'd101, 1'b1);
      send_fields(rlyatt_pkg::OP_BOTH_RAW, 8'd0, 1'b0);
      send_fields(rlyatt_pkg::OP_BOTH_RAW, 8'd255, 1'b1);
      send_fields(rlyatt_pkg::OP_BOTH_RAW, 8'd170, 1'b0);
      send_fields(rlyatt_pkg::OP_ONE_RAW, 8'd0, 1'b0);
      send_fields(rlyatt_pkg::OP_ONE_RAW, 8'd255, 1'b1);
      send_fields(rlyatt_pkg::OP_ONE_RAW, 8'd85, 1'b1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case (phase)
            0: configure(rlyatt_pkg::BALANCE_MAX, rlyatt_pkg::EXTRA_RESET, 8'hff);
            1: configure(rlyatt_pkg::BALANCE_MIN, rlyatt_pkg::CODE_MAX, 8'h00);
            // Out-of-range balance values must leave the previous setting in place.
            2: configure(rlyatt_pkg::BALANCE_MAX + 8'd1, 8'd37, 8'h85);
            3: configure(rlyatt_pkg::BALANCE_MIN - 8'd1, 8'd0, 8'd1);
            4: configure(rlyatt_pkg::BALANCE_CENTER, random_extra(),
                         8'($urandom_range(0, 255)));
            default: configure(8'($urandom_range(0, 255)), random_extra(),
                               8'($urandom_range(0, 255)));
         endcase
         steady = (phase == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
      end
      steady = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests (%0d rejected) under %0d register settings.",
               scoreboard.requests_noted, scoreboard.rejects_noted, settings_used);
      $display("Checked %0d result words against the predicted sequences.",
               scoreboard.words_checked);
      if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/rlyatt_pkg.sv
hdl/rlyatt_front.sv
hdl/rlyatt_queue.sv
hdl/rlyatt_back.sv
hdl/relay_attenuator_sequencer.sv
dv/relay_attenuator_sequencer_tb.sv
